>>> hdl/pcxrt_pkg.sv
package pcxrt_pkg;

    localparam int DEF_MAX_TILE_COLUMNS = 128;
    localparam int DEF_MAX_BANDS        = 128;

    localparam logic [7:0] RUN_MARK = 8'hc0;
    localparam logic [7:0] RUN_MASK = 8'h3f;

    localparam logic [7:0] WIDTH_TILES_RST  = 8'd32;
    localparam logic [7:0] HEIGHT_BANDS_RST = 8'd24;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_TILES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_BANDS = 2'd1;

    localparam logic [3:0] GROUP_PIXELS = 4'd8;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef logic [3:0][7:0] plane_word_t;

    typedef struct packed {
        logic [6:0]  tile_column;
        logic [2:0]  row_in_tile;
        logic [6:0]  band_index;
        logic [11:0] offset_in_band;
        logic        done;
        logic        done_adv;
    } tile_pos_t;

endpackage

>>> hdl/pcxrt_planes.sv
module pcxrt_planes import pcxrt_pkg::*; (
    input  logic        aclk,
    input  logic        shift_en,
    input  logic [3:0]  shift_count,
    input  logic [3:0]  pixel,
    output plane_word_t planes_next
);

    plane_word_t planes_reg;
    logic [8:0]  fill_mask;

    assign fill_mask = (9'd1 << shift_count) - 9'd1;

    // shift in up to eight copies of the pixel, leftmost pixel ends in bit 7
    always_comb begin
        for (int p = 0; p < 4; p++) begin
            if (shift_en) begin
                planes_next[p] = (planes_reg[p] << shift_count)
                               | (pixel[p] ? fill_mask[7:0] : 8'h00);
            end else begin
                planes_next[p] = planes_reg[p];
            end
        end
    end

    always_ff @(posedge aclk) begin
        planes_reg <= planes_next;
    end

endmodule

>>> hdl/pcxrt_tilepos.sv
module pcxrt_tilepos import pcxrt_pkg::*; #(
    parameter int COL_W  = 8,
    parameter int BAND_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic [COL_W-1:0]  eff_width,
    input  logic [BAND_W-1:0] eff_height,
    output tile_pos_t         pos
);

    logic [COL_W-1:0]  col_reg, col_next;
    logic [2:0]        scan_reg, scan_next;
    logic [BAND_W-1:0] band_reg, band_next;
    logic              line_end;
    logic              band_step;
    logic [BAND_W-1:0] band_after;

    assign line_end   = ({1'b0, col_reg} + {{COL_W{1'b0}}, 1'b1}) >= {1'b0, eff_width};
    assign band_step  = line_end && (scan_reg == 3'd7);
    assign band_after = band_reg + {{(BAND_W-1){1'b0}}, band_step};

    assign pos.tile_column    = col_reg[6:0];
    assign pos.row_in_tile    = scan_reg;
    assign pos.band_index     = band_reg[6:0];
    assign pos.offset_in_band = {col_reg[6:0], scan_reg, 2'b00};
    assign pos.done           = band_reg >= eff_height;
    assign pos.done_adv       = band_after >= eff_height;

    always_comb begin
        col_next  = col_reg;
        scan_next = scan_reg;
        band_next = band_reg;
        if (advance) begin
            if (line_end) begin
                col_next  = '0;
                scan_next = scan_reg + 3'd1;
                band_next = band_after;
            end else begin
                col_next = col_reg + {{(COL_W-1){1'b0}}, 1'b1};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            scan_reg <= '0;
            band_reg <= '0;
        end else begin
            col_reg  <= col_next;
            scan_reg <= scan_next;
            band_reg <= band_next;
        end
    end

endmodule

>>> hdl/pcx_rle_to_planar_tiles.sv
// PCX run-length decoder to 4bpp planar 8x8 tiles. Each data byte is one word on
// the s_ channel; each completed group of eight pixels leaves as one m_ word with
// its four plane bytes and tile position, m_last marking the final word of that
// input byte. A marker byte or an ignored byte is accepted alone; a pixel byte or a
// run is accepted and then fills the plane shift registers, which take up to eight
// pixels a cycle unless a completed group waits, and no new byte is taken until the
// run is through. A fill that completes a group waits while the output register
// still holds a word not taken. Once height_bands bands are complete all bytes
// are taken and dropped. No clearing pass follows reset.
module pcx_rle_to_planar_tiles import pcxrt_pkg::*; #(
    parameter int MAX_TILE_COLUMNS = DEF_MAX_TILE_COLUMNS,
    parameter int MAX_BANDS        = DEF_MAX_BANDS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_data_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_plane0,
    output logic [7:0]           m_plane1,
    output logic [7:0]           m_plane2,
    output logic [7:0]           m_plane3,
    output logic [6:0]           m_tile_column,
    output logic [2:0]           m_row_in_tile,
    output logic [6:0]           m_band_index,
    output logic [11:0]          m_offset_in_band,
    output logic                 m_last
);

    localparam int COL_W  = ($clog2(MAX_TILE_COLUMNS + 1) > 8) ?
                            $clog2(MAX_TILE_COLUMNS + 1) : 8;
    localparam int BAND_W = ($clog2(MAX_BANDS + 1) > 8) ? $clog2(MAX_BANDS + 1) : 8;

    logic [7:0]  width_tiles_reg;
    logic [7:0]  height_bands_reg;
    state_t      state_reg, state_next;
    logic        run_pending_reg, run_pending_next;
    logic [5:0]  pending_count_reg, pending_count_next;
    logic [5:0]  remain_reg, remain_next;
    logic [3:0]  pixel_reg, pixel_next;
    logic [2:0]  pidx_reg, pidx_next;

    logic        m_valid_reg, m_valid_next;
    plane_word_t m_planes_reg;
    logic [6:0]  m_tile_column_reg;
    logic [2:0]  m_row_in_tile_reg;
    logic [6:0]  m_band_index_reg;
    logic [11:0] m_offset_in_band_reg;
    logic        m_last_reg;

    logic [COL_W-1:0]  width_ext;
    logic [COL_W-1:0]  eff_width;
    logic [BAND_W-1:0] height_ext;
    logic [BAND_W-1:0] eff_height;

    logic [3:0]  space;
    logic [3:0]  chunk;
    logic [5:0]  remain_after;
    logic        group_full;
    logic        out_free;
    logic        step;
    logic        emit;
    logic        last_flag;
    logic        finish;
    logic        accept;

    tile_pos_t   pos;
    plane_word_t planes_next;

    assign width_ext  = COL_W'(width_tiles_reg);
    assign height_ext = BAND_W'(height_bands_reg);
    assign eff_width  = (width_ext == '0) ? COL_W'(1) :
                        (width_ext > COL_W'(MAX_TILE_COLUMNS)) ?
                        COL_W'(MAX_TILE_COLUMNS) : width_ext;
    assign eff_height = (height_ext > BAND_W'(MAX_BANDS)) ? BAND_W'(MAX_BANDS) : height_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_tiles_reg  <= WIDTH_TILES_RST;
            height_bands_reg <= HEIGHT_BANDS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_WIDTH_TILES:  width_tiles_reg  <= cfg_wdata;
                CFG_HEIGHT_BANDS: height_bands_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign space        = GROUP_PIXELS - {1'b0, pidx_reg};
    assign chunk        = (remain_reg < {2'b00, space}) ? remain_reg[3:0] : space;
    assign remain_after = remain_reg - {2'b00, chunk};
    assign group_full   = (chunk == space);
    assign out_free     = !m_valid_reg || m_ready;
    assign step         = (state_reg == ST_RUN) && (!group_full || out_free);
    assign emit         = step && group_full;
    assign last_flag    = (remain_after < 6'd8) || pos.done_adv;
    assign finish       = step && ((remain_after == '0) || (group_full && pos.done_adv));
    assign s_ready      = (state_reg == ST_IDLE);
    assign accept       = s_valid && s_ready;

    always_comb begin
        state_next         = state_reg;
        run_pending_next   = run_pending_reg;
        pending_count_next = pending_count_reg;
        remain_next        = remain_reg;
        pixel_next         = pixel_reg;
        pidx_next          = pidx_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (accept && !pos.done) begin
                    if (run_pending_reg) begin
                        run_pending_next = 1'b0;
                        remain_next      = pending_count_reg;
                        pixel_next       = s_data_byte[3:0];
                        if (pending_count_reg != '0) begin
                            state_next = ST_RUN;
                        end
                    end else if ((s_data_byte & RUN_MARK) == RUN_MARK) begin
                        run_pending_next   = 1'b1;
                        pending_count_next = s_data_byte[5:0] & RUN_MASK[5:0];
                    end else begin
                        remain_next = 6'd1;
                        pixel_next  = s_data_byte[3:0];
                        state_next  = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (step) begin
                    remain_next = remain_after;
                    pidx_next   = group_full ? 3'd0 : pidx_reg + chunk[2:0];
                    if (finish) begin
                        state_next = ST_IDLE;
                    end
                end
                if (emit) begin
                    m_valid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            run_pending_reg   <= 1'b0;
            pending_count_reg <= '0;
            remain_reg        <= '0;
            pidx_reg          <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            run_pending_reg   <= run_pending_next;
            pending_count_reg <= pending_count_next;
            remain_reg        <= remain_next;
            pidx_reg          <= pidx_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pixel_reg <= pixel_next;
        if (emit) begin
            m_planes_reg         <= planes_next;
            m_tile_column_reg    <= pos.tile_column;
            m_row_in_tile_reg    <= pos.row_in_tile;
            m_band_index_reg     <= pos.band_index;
            m_offset_in_band_reg <= pos.offset_in_band;
            m_last_reg           <= last_flag;
        end
    end

    pcxrt_planes u_planes (
        .aclk        (aclk),
        .shift_en    (step),
        .shift_count (chunk),
        .pixel       (pixel_reg),
        .planes_next (planes_next)
    );

    pcxrt_tilepos #(
        .COL_W  (COL_W),
        .BAND_W (BAND_W)
    ) u_tilepos (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (emit),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .pos        (pos)
    );

    assign m_valid          = m_valid_reg;
    assign m_plane0         = m_planes_reg[0];
    assign m_plane1         = m_planes_reg[1];
    assign m_plane2         = m_planes_reg[2];
    assign m_plane3         = m_planes_reg[3];
    assign m_tile_column    = m_tile_column_reg;
    assign m_row_in_tile    = m_row_in_tile_reg;
    assign m_band_index     = m_band_index_reg;
    assign m_offset_in_band = m_offset_in_band_reg;
    assign m_last           = m_last_reg;

endmodule

>>> hdl/pcxrt_checker.sv
module pcxrt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_plane0,
    input logic [7:0]  m_plane1,
    input logic [7:0]  m_plane2,
    input logic [7:0]  m_plane3,
    input logic [6:0]  m_tile_column,
    input logic [2:0]  m_row_in_tile,
    input logic [11:0] m_offset_in_band
);

    a_word_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped before it was taken");

    a_planes_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_plane0) && $stable(m_plane1)
                                && $stable(m_plane2) && $stable(m_plane3))
        else $error("plane bytes changed while stalled");

    a_offset_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_offset_in_band == {m_tile_column, m_row_in_tile, 2'b00})
        else $error("band offset does not match tile column and row");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");

endmodule

bind pcx_rle_to_planar_tiles pcxrt_checker u_pcxrt_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_plane0         (m_plane0),
    .m_plane1         (m_plane1),
    .m_plane2         (m_plane2),
    .m_plane3         (m_plane3),
    .m_tile_column    (m_tile_column),
    .m_row_in_tile    (m_row_in_tile),
    .m_offset_in_band (m_offset_in_band)
);

>>> dv/testbench.sv
module testbench;
    import pcxrt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE0 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE1 = 2'd3;
    localparam int unsigned RANDOM_BYTES = 170;
    localparam int unsigned SETTLE_CYCLES = 24;
    localparam int unsigned LONG_HOLD = 400;

    typedef struct {
        logic [7:0]  plane0;
        logic [7:0]  plane1;
        logic [7:0]  plane2;
        logic [7:0]  plane3;
        logic [6:0]  tile_column;
        logic [2:0]  row_in_tile;
        logic [6:0]  band_index;
        logic [11:0] offset_in_band;
        logic        last;
    } tile_word_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_data_byte = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [7:0]           m_plane0;
    logic [7:0]           m_plane1;
    logic [7:0]           m_plane2;
    logic [7:0]           m_plane3;
    logic [6:0]           m_tile_column;
    logic [2:0]           m_row_in_tile;
    logic [6:0]           m_band_index;
    logic [11:0]          m_offset_in_band;
    logic                 m_last;

    pcx_rle_to_planar_tiles dut (.*);

    // decoder state as seen from outside
    logic [7:0]  width_reg = WIDTH_TILES_RST;
    logic [7:0]  height_reg = HEIGHT_BANDS_RST;
    bit          run_armed = 1'b0;
    logic [5:0]  run_len = '0;
    logic [31:0] planes = '0;
    int unsigned pix_idx = 0;
    int unsigned col_cnt = 0;
    int unsigned line_cnt = 0;
    int unsigned band_cnt = 0;

    logic [7:0]  rle_bytes[$];
    tile_word_t  tile_words_due[$];
    int unsigned queued_total = 0;
    int unsigned taken_total = 0;
    int unsigned err_count = 0;
    int unsigned tx_idle_pct = 28;
    int unsigned rx_idle_pct = 71;
    bit          hold_req = 1'b0;
    bit          hold_taken = 1'b0;
    int unsigned hold_left = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int unsigned eff_height();
        return (height_reg > DEF_MAX_BANDS) ? DEF_MAX_BANDS : height_reg;
    endfunction

    task automatic decode_byte(input logic [7:0] b);
        tile_word_t  batch[$];
        tile_word_t  w;
        logic [7:0]  pix;
        int unsigned count;
        int unsigned sh;
        int unsigned line_tiles;
        line_tiles = (width_reg == 0) ? 1 :
                     (width_reg > DEF_MAX_TILE_COLUMNS) ? DEF_MAX_TILE_COLUMNS : width_reg;
        if (band_cnt >= eff_height())
            return;
        if (run_armed) begin
            run_armed = 1'b0;
            count = run_len;
            pix = b;
        end else if ((b & RUN_MARK) == RUN_MARK) begin
            run_armed = 1'b1;
            run_len = b[5:0] & RUN_MASK[5:0];
            return;
        end else begin
            count = 1;
            pix = b;
        end
        for (int i = 0; i < count; i++) begin
            if (band_cnt >= eff_height())
                break;
            sh = 7 - pix_idx;
            for (int p = 0; p < 4; p++)
                if (pix[p])
                    planes[8*p + sh] = 1'b1;
            if (pix_idx == 7) begin
                w.plane0 = planes[7:0];
                w.plane1 = planes[15:8];
                w.plane2 = planes[23:16];
                w.plane3 = planes[31:24];
                w.tile_column = 7'(col_cnt);
                w.row_in_tile = 3'(line_cnt);
                w.band_index = 7'(band_cnt);
                w.offset_in_band = 12'(col_cnt * 32 + line_cnt * 4);
                w.last = 1'b0;
                batch.push_back(w);
                planes = '0;
                pix_idx = 0;
                if (col_cnt + 1 >= line_tiles) begin
                    col_cnt = 0;
                    if (line_cnt >= 7) begin
                        line_cnt = 0;
                        band_cnt++;
                    end else begin
                        line_cnt++;
                    end
                end else begin
                    col_cnt++;
                end
            end else begin
                pix_idx++;
            end
        end
        if (batch.size() != 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k])
            tile_words_due.push_back(batch[k]);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data_byte <= '0;
        end else begin
            if (s_valid && s_ready) begin
                decode_byte(s_data_byte);
                taken_total++;
            end
            if (!s_valid || s_ready) begin
                if (rle_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data_byte <= rle_bytes.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            m_ready <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_taken <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin : tile_monitor
        tile_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (tile_words_due.size() == 0) begin
                $display("%0t: word expected none got col %0d row %0d band %0d last %0d",
                         $time, m_tile_column, m_row_in_tile, m_band_index, m_last);
                err_count++;
            end else begin
                want = tile_words_due.pop_front();
                check_field("plane0", want.plane0, m_plane0);
                check_field("plane1", want.plane1, m_plane1);
                check_field("plane2", want.plane2, m_plane2);
                check_field("plane3", want.plane3, m_plane3);
                check_field("tile_column", want.tile_column, m_tile_column);
                check_field("row_in_tile", want.row_in_tile, m_row_in_tile);
                check_field("band_index", want.band_index, m_band_index);
                check_field("offset_in_band", want.offset_in_band, m_offset_in_band);
                check_field("last", want.last, m_last);
            end
        end
    end

    task automatic put(input logic [7:0] b);
        rle_bytes.push_back(b);
        queued_total++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_WIDTH_TILES)
            width_reg = val;
        else if (idx == CFG_HEIGHT_BANDS)
            height_reg = val;
    endtask

    task automatic settle();
        do @(negedge aclk);
        while (taken_total != queued_total || tile_words_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic fill_phase(input int unsigned n);
        int unsigned r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 40) begin
                put(8'($urandom_range(0, 191)));
            end else if (r < 90) begin
                if ($urandom_range(15) == 0)
                    put(RUN_MARK);
                else
                    put(RUN_MARK | (8'($urandom) & RUN_MASK));
                put(8'($urandom));
            end else begin
                put(8'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        int unsigned phase;
        int unsigned done;
        int unsigned start_count;
        logic [7:0]  w;
        logic [7:0]  h;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        write_reg(CFG_WIDTH_TILES, 8'd1);
        write_reg(CFG_HEIGHT_BANDS, 8'd2);
        write_reg(CFG_SPARE1, 8'hff);
        // one full group, then a zero run, long runs across lines and past the end
        put(8'h00); put(8'h3f); put(8'h15); put(8'hbf);
        put(8'h80); put(8'h7a); put(8'h4c); put(8'h21);
        put(RUN_MARK); put(8'h55);
        put(RUN_MARK | RUN_MASK); put(8'hff);
        put(RUN_MARK | 8'd5); put(8'ha3);
        put(RUN_MARK | RUN_MASK); put(8'h0c);
        put(RUN_MARK | 8'd3); put(8'h11); put(8'h05);
        settle();

        start_count = queued_total;
        phase = 0;
        while (queued_total - start_count < RANDOM_BYTES && phase < 48) begin
            done = queued_total - start_count;
            case (done * 3 / RANDOM_BYTES)
                0: begin
                    tx_idle_pct = 28;
                    rx_idle_pct = 71;
                end
                1: begin
                    tx_idle_pct = 71;
                    rx_idle_pct = 28;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            case (phase)
                0: begin
                    w = 8'd0;
                    h = 8'(band_cnt + 2);
                end
                1: begin
                    w = 8'd255;
                    h = 8'd255;
                end
                2: begin
                    w = 8'd3;
                    h = 8'd0;
                end
                3: begin
                    w = 8'd128;
                    h = 8'd128;
                end
                default: begin
                    w = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6));
                    h = 8'(band_cnt + (($urandom_range(3) == 0) ? 1 : $urandom_range(2, 4)));
                end
            endcase
            write_reg(CFG_WIDTH_TILES, w);
            write_reg(CFG_HEIGHT_BANDS, h);
            if (phase == 0 || $urandom_range(3) == 0)
                write_reg($urandom_range(1) ? CFG_SPARE0 : CFG_SPARE1, 8'($urandom));
            if (phase == 4)
                hold_req = 1'b1;
            fill_phase((h == 0) ? 6 : $urandom_range(15, 30));
            settle();
            phase++;
        end

        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("FAIL");
        $finish;
    end

endmodule
